[hdl/mailbox_register_block_defines.svh]
// assertion macros for the mailbox register block
`ifndef MAILBOX_REGISTER_BLOCK_DEFINES_SVH
`define MAILBOX_REGISTER_BLOCK_DEFINES_SVH

`ifndef SYNTHESIS
`define MBX_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mailbox assertion failed");
`define MBX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mailbox assertion failed");
`else
`define MBX_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define MBX_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[hdl/mbx_pkg.sv]
// types and constants of the mailbox register block
package mbx_pkg;

   localparam int unsigned ADDR_W = 6;
   localparam int unsigned DATA_W = 64;
   localparam int unsigned WORD_W = 32;

   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   localparam logic [ADDR_W-1:0] WORD_TXCFG_LO = 6'd0;
   localparam logic [ADDR_W-1:0] WORD_TXCFG_HI = 6'd1;
   localparam logic [ADDR_W-1:0] WORD_TXDAT_LO = 6'd2;
   localparam logic [ADDR_W-1:0] WORD_TXDAT_HI = 6'd3;
   localparam logic [ADDR_W-1:0] WORD_RX_LO    = 6'd4;
   localparam logic [ADDR_W-1:0] WORD_RX_HI    = 6'd5;
   localparam logic [ADDR_W-1:0] WORD_PEND     = 6'd6;
   localparam logic [ADDR_W-1:0] WORD_MASK     = 6'd7;
   localparam logic [ADDR_W-1:0] WORD_STATUS   = 6'd8;

   localparam logic [WORD_W-1:0] IRQ_RX_VALID = 32'h0000_0001;
   localparam logic [WORD_W-1:0] IRQ_RX_UDR   = 32'h0000_0002;
   localparam logic [WORD_W-1:0] IRQ_ALL      = 32'h0000_0003;

   localparam logic [WORD_W-1:0] STATUS_INIT =
      (32'h1 << 5) | (32'h1 << 6) | (32'hf << 8) | (32'h1 << 13) | (32'h1 << 21);
   localparam logic [WORD_W-1:0] MASK_INIT = 32'hffff_ffff;

   localparam logic [1:0] TARGET_PF    = 2'd0;
   localparam logic [1:0] TARGET_LOCAL = 2'd3;

   localparam logic [1:0] SEND_OK          = 2'd0;
   localparam logic [1:0] SEND_UNSUPPORTED = 2'd1;
   localparam logic [1:0] SEND_ABSENT      = 2'd2;

   localparam logic [4:0] MGMT_FN_FIRST = 5'h10;
   localparam logic [4:0] MGMT_FN_LAST  = 5'h12;

   typedef struct packed {
      logic              req_type;
      logic [ADDR_W-1:0] word_addr;
      logic              wide_access;
      logic [DATA_W-1:0] write_data;
   } req_payload_type;

   typedef struct packed {
      logic              access_ok;
      logic [DATA_W-1:0] read_data;
      logic              irq_line;
      logic              send_valid;
      logic [DATA_W-1:0] send_cfg;
      logic [DATA_W-1:0] send_data;
      logic [1:0]        send_target;
      logic [1:0]        send_bank;
      logic [2:0]        send_index;
      logic [1:0]        send_status;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0] target;
      logic [1:0] bank;
      logic [2:0] index;
      logic [1:0] status;
   } send_type;

endpackage

[hdl/mbx_chan_if.sv]
// valid/ready channel carrying one payload per transfer
interface mbx_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[hdl/mailbox_register_block.sv]
// mailbox register block: a transferred request is held in the request register,
// decoded and held in the response register, which drives response valid; one
// access per cycle via the single decode stage; a stalled response holds the stage
// synchronous reset clears the register file, status and mask to their initial
// values, empties the receive queue and drops the interrupt; queue entries are
// not cleared and the core present mask returns to all ones
`include "mailbox_register_block_defines.svh"

module mailbox_register_block
   import mbx_pkg::*;
#(
   parameter int unsigned REG_WORDS = 64,
   parameter int unsigned RX_DEPTH  = 16
) (
   input logic         clock,
   input logic         reset,
   mbx_chan_if.sink    req_chan,
   mbx_chan_if.source  rsp_chan,
   mbx_chan_if.sink    csr_chan
);

   localparam int unsigned RX_IDX_W    = $clog2(RX_DEPTH);
   localparam int unsigned RX_CNT_W    = $clog2(RX_DEPTH + 1);
   localparam int unsigned ADDR_SPAN   = 1 << ADDR_W;
   localparam int unsigned STORE_WORDS = (REG_WORDS < ADDR_SPAN) ? REG_WORDS : ADDR_SPAN;
   localparam int unsigned EVEN_DEPTH  = (STORE_WORDS + 1) / 2;
   localparam int unsigned ODD_DEPTH   = STORE_WORDS / 2;
   localparam int unsigned EVEN_AW     = $clog2(EVEN_DEPTH);
   localparam int unsigned ODD_AW      = $clog2(ODD_DEPTH);
   localparam logic [ADDR_W:0]   EXT_ADDR  = (ADDR_W + 1)'(ADDR_SPAN);
   localparam logic [RX_CNT_W:0] DEPTH_EXT = (RX_CNT_W + 1)'(RX_DEPTH);
   localparam logic [RX_IDX_W:0] DEPTH_IDX = (RX_IDX_W + 1)'(RX_DEPTH);

   function automatic logic [WORD_W-1:0] merge_word(
      input logic [WORD_W-1:0] cur,
      input logic [ADDR_W-1:0] k,
      input logic [ADDR_W:0]   lo_a,
      input logic [ADDR_W:0]   hi_a,
      input logic              wide,
      input logic [DATA_W-1:0] d
   );
      logic [WORD_W-1:0] r;
      r = cur;
      if (lo_a == {1'b0, k}) begin
         r = d[WORD_W-1:0];
      end else if (wide && (hi_a == {1'b0, k})) begin
         r = d[DATA_W-1:WORD_W];
      end
      return r;
   endfunction

   function automatic send_type decode_send(
      input logic [DATA_W-1:0] cfg,
      input logic [WORD_W-1:0] present
   );
      logic [7:0] dst;
      logic [4:0] fn;
      send_type   s;
      dst = cfg[15:8];
      fn  = dst[4:0];
      s   = '0;
      if (dst[7]) begin
         if (fn inside {[MGMT_FN_FIRST:MGMT_FN_LAST]}) begin
            s.target = 2'(fn - MGMT_FN_FIRST);
         end else begin
            s.target = TARGET_PF;
            s.status = SEND_UNSUPPORTED;
         end
      end else begin
         s.target = TARGET_LOCAL;
         s.bank   = dst[4:3];
         s.index  = dst[2:0];
         if ((dst[6:5] != 2'b00) || !present[dst[4:0]]) begin
            s.status = SEND_ABSENT;
         end else begin
            s.status = SEND_OK;
         end
      end
      return s;
   endfunction

   // handshake and stage registers
   req_payload_type s1_ff, s1_in;
   logic            s1_valid_ff, s1_valid_in;
   rsp_payload_type rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            req_ready;
   logic            req_xfer;
   logic            s1_adv;

   // register file
   logic [WORD_W-1:0] txcfg_lo_ff, txcfg_lo_in;
   logic [WORD_W-1:0] txcfg_hi_ff, txcfg_hi_in;
   logic [WORD_W-1:0] txdat_lo_ff, txdat_lo_in;
   logic [WORD_W-1:0] txdat_hi_ff, txdat_hi_in;
   logic [WORD_W-1:0] rxw_lo_ff, rxw_lo_in;
   logic [WORD_W-1:0] rxw_hi_ff, rxw_hi_in;
   logic [WORD_W-1:0] pend_ff, pend_in;
   logic [WORD_W-1:0] mask_ff, mask_in;
   logic [WORD_W-1:0] ext_word_ff, ext_word_in;
   logic [WORD_W-1:0] even_bank_ff [0:EVEN_DEPTH-1];
   logic [WORD_W-1:0] odd_bank_ff [0:ODD_DEPTH-1];
   logic              even_we, odd_we;
   logic [WORD_W-1:0] even_wdata, odd_wdata;
   logic [EVEN_AW-1:0] even_idx;
   logic [ODD_AW-1:0]  odd_idx;
   logic [WORD_W-1:0] even_rd, odd_rd, lo_bank, hi_bank, lo_word, hi_word;

   // interrupt, configuration and receive queue
   logic                irq_ff, irq_in;
   logic [WORD_W-1:0]   present_ff, present_in;
   logic [RX_IDX_W-1:0] rx_head_ff, rx_head_in, rx_head_next, rx_tail;
   logic [RX_CNT_W-1:0] rx_count_ff, rx_count_in;
   logic [RX_IDX_W:0]   rx_head_inc;
   logic [RX_CNT_W:0]   rx_tail_sum;
   logic                rx_we;
   logic [DATA_W-1:0]   rx_wdata, rx_rd_data;

   // decode of the staged access
   logic [ADDR_W-1:0] w;
   logic [ADDR_W:0]   a_lo, a_hi;
   logic [ADDR_W+1:0] span_end;
   logic              in_range, is_write, wide, is_rx;
   logic              lo_in_bank, hi_in_bank;
   logic [DATA_W-1:0] d;

   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_xfer  = req_chan.valid && req_ready;
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;
   assign csr_chan.ready   = 1'b1;

   assign s1_valid_in  = req_xfer || (s1_valid_ff && !s1_adv);
   assign s1_in        = req_xfer ? req_chan.payload : s1_ff;
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_chan.ready);
   assign present_in   = csr_chan.valid ? csr_chan.payload : present_ff;

   assign w          = s1_ff.word_addr;
   assign wide       = s1_ff.wide_access;
   assign is_write   = (s1_ff.req_type == REQ_WRITE);
   assign d          = s1_ff.write_data;
   assign a_lo       = {1'b0, w};
   assign a_hi       = a_lo + (ADDR_W + 1)'(1);
   assign span_end   = {2'b00, w} + (wide ? (ADDR_W + 2)'(2) : (ADDR_W + 2)'(1));
   assign in_range   = (32'(span_end) <= REG_WORDS);
   assign is_rx      = w inside {WORD_RX_LO, WORD_RX_HI};
   assign lo_in_bank = (a_lo > {1'b0, WORD_STATUS}) && (a_lo < EXT_ADDR);
   assign hi_in_bank = (a_hi > {1'b0, WORD_STATUS}) && (a_hi < EXT_ADDR);

   // even and odd word banks
   assign even_idx   = a_lo[0] ? a_hi[EVEN_AW:1] : a_lo[EVEN_AW:1];
   assign odd_idx    = a_lo[0] ? a_lo[ODD_AW:1] : a_hi[ODD_AW:1];
   assign even_rd    = even_bank_ff[even_idx];
   assign odd_rd     = odd_bank_ff[odd_idx];
   assign lo_bank    = a_lo[0] ? odd_rd : even_rd;
   assign hi_bank    = a_lo[0] ? even_rd : odd_rd;
   assign even_wdata = a_lo[0] ? d[DATA_W-1:WORD_W] : d[WORD_W-1:0];
   assign odd_wdata  = a_lo[0] ? d[WORD_W-1:0] : d[DATA_W-1:WORD_W];

   always_comb begin
      case (a_lo)
         {1'b0, WORD_TXCFG_LO}: lo_word = txcfg_lo_ff;
         {1'b0, WORD_TXCFG_HI}: lo_word = txcfg_hi_ff;
         {1'b0, WORD_TXDAT_LO}: lo_word = txdat_lo_ff;
         {1'b0, WORD_TXDAT_HI}: lo_word = txdat_hi_ff;
         {1'b0, WORD_RX_LO}:    lo_word = rxw_lo_ff;
         {1'b0, WORD_RX_HI}:    lo_word = rxw_hi_ff;
         {1'b0, WORD_PEND}:     lo_word = pend_ff;
         {1'b0, WORD_MASK}:     lo_word = mask_ff;
         {1'b0, WORD_STATUS}:   lo_word = STATUS_INIT;
         default:               lo_word = lo_bank;
      endcase
   end

   always_comb begin
      case (a_hi)
         {1'b0, WORD_TXCFG_LO}: hi_word = txcfg_lo_ff;
         {1'b0, WORD_TXCFG_HI}: hi_word = txcfg_hi_ff;
         {1'b0, WORD_TXDAT_LO}: hi_word = txdat_lo_ff;
         {1'b0, WORD_TXDAT_HI}: hi_word = txdat_hi_ff;
         {1'b0, WORD_RX_LO}:    hi_word = rxw_lo_ff;
         {1'b0, WORD_RX_HI}:    hi_word = rxw_hi_ff;
         {1'b0, WORD_PEND}:     hi_word = pend_ff;
         {1'b0, WORD_MASK}:     hi_word = mask_ff;
         {1'b0, WORD_STATUS}:   hi_word = STATUS_INIT;
         default:               hi_word = (a_hi == EXT_ADDR) ? ext_word_ff : hi_bank;
      endcase
   end

   // receive queue pointers
   assign rx_head_inc  = {1'b0, rx_head_ff} + (RX_IDX_W + 1)'(1);
   assign rx_head_next = (rx_head_inc == DEPTH_IDX) ? '0 : rx_head_inc[RX_IDX_W-1:0];
   assign rx_tail_sum  = (RX_CNT_W + 1)'(rx_head_ff) + (RX_CNT_W + 1)'(rx_count_ff);
   assign rx_tail      = (rx_tail_sum >= DEPTH_EXT) ? RX_IDX_W'(rx_tail_sum - DEPTH_EXT)
                                                    : RX_IDX_W'(rx_tail_sum);
   assign rx_wdata     = {rxw_hi_in, rxw_lo_in};

   always_comb begin
      logic              refresh;
      logic              clear_irq;
      logic [DATA_W-1:0] rx_word;
      send_type          snd;
      txcfg_lo_in = txcfg_lo_ff;
      txcfg_hi_in = txcfg_hi_ff;
      txdat_lo_in = txdat_lo_ff;
      txdat_hi_in = txdat_hi_ff;
      rxw_lo_in   = rxw_lo_ff;
      rxw_hi_in   = rxw_hi_ff;
      pend_in     = pend_ff;
      mask_in     = mask_ff;
      ext_word_in = ext_word_ff;
      irq_in      = irq_ff;
      rx_head_in  = rx_head_ff;
      rx_count_in = rx_count_ff;
      rx_we       = 1'b0;
      even_we     = 1'b0;
      odd_we      = 1'b0;
      rsp_in      = '0;
      refresh     = 1'b0;
      clear_irq   = 1'b0;
      rx_word     = '0;
      snd         = '0;
      if (s1_adv) begin
         rsp_in.access_ok = 1'b1;
         if (!in_range) begin
            rsp_in.access_ok = 1'b0;
         end else if (!is_write) begin
            if (is_rx) begin
               if (rx_count_ff == '0) begin
                  // read of an empty queue
                  pend_in = pend_ff | IRQ_RX_UDR;
                  refresh = 1'b1;
               end else begin
                  rx_word = (w == WORD_RX_HI) ? {32'b0, rx_rd_data[DATA_W-1:WORD_W]}
                                              : rx_rd_data;
                  if ((wide && (w == WORD_RX_LO)) || (w == WORD_RX_HI)) begin
                     rx_head_in  = rx_head_next;
                     rx_count_in = rx_count_ff - RX_CNT_W'(1);
                  end
                  rsp_in.read_data = wide ? rx_word : {32'b0, rx_word[WORD_W-1:0]};
               end
            end else begin
               rsp_in.read_data = {wide ? hi_word : 32'b0, lo_word};
            end
         end else if (w == WORD_STATUS) begin
            rsp_in.access_ok = 1'b0;
         end else if (w == WORD_PEND) begin
            if (pend_ff != '0) begin
               pend_in   = pend_ff & ~d[WORD_W-1:0];
               clear_irq = (pend_in == '0);
            end
         end else if (w == WORD_MASK) begin
            mask_in = d[WORD_W-1:0];
            refresh = 1'b1;
         end else begin
            txcfg_lo_in = merge_word(txcfg_lo_ff, WORD_TXCFG_LO, a_lo, a_hi, wide, d);
            txcfg_hi_in = merge_word(txcfg_hi_ff, WORD_TXCFG_HI, a_lo, a_hi, wide, d);
            txdat_lo_in = merge_word(txdat_lo_ff, WORD_TXDAT_LO, a_lo, a_hi, wide, d);
            txdat_hi_in = merge_word(txdat_hi_ff, WORD_TXDAT_HI, a_lo, a_hi, wide, d);
            rxw_lo_in   = merge_word(rxw_lo_ff, WORD_RX_LO, a_lo, a_hi, wide, d);
            rxw_hi_in   = merge_word(rxw_hi_ff, WORD_RX_HI, a_lo, a_hi, wide, d);
            pend_in     = merge_word(pend_ff, WORD_PEND, a_lo, a_hi, wide, d);
            if (wide && (a_hi == EXT_ADDR)) begin
               ext_word_in = d[DATA_W-1:WORD_W];
            end
            even_we = (lo_in_bank && !a_lo[0]) || (wide && hi_in_bank && !a_hi[0]);
            odd_we  = (lo_in_bank && a_lo[0]) || (wide && hi_in_bank && a_hi[0]);
            if ((wide && (w == WORD_TXDAT_LO)) || (!wide && (w == WORD_TXDAT_HI))) begin
               snd                = decode_send({txcfg_hi_in, txcfg_lo_in}, present_ff);
               rsp_in.send_valid  = 1'b1;
               rsp_in.send_cfg    = {txcfg_hi_in, txcfg_lo_in};
               rsp_in.send_data   = {txdat_hi_in, txdat_lo_in};
               rsp_in.send_target = snd.target;
               rsp_in.send_bank   = snd.bank;
               rsp_in.send_index  = snd.index;
               rsp_in.send_status = snd.status;
            end else if ((wide && (w == WORD_RX_LO)) || (w == WORD_RX_HI)) begin
               // full queue drops the word
               if (32'(rx_count_ff) < RX_DEPTH) begin
                  rx_we       = 1'b1;
                  rx_count_in = rx_count_ff + RX_CNT_W'(1);
                  if (rx_count_ff[0]) begin
                     pend_in = pend_in | IRQ_RX_VALID;
                     refresh = 1'b1;
                  end
               end
            end
         end
         if (refresh && ((pend_in & ~mask_in & IRQ_ALL) != '0)) begin
            irq_in = 1'b1;
         end
         if (clear_irq) begin
            irq_in = 1'b0;
         end
         rsp_in.irq_line = irq_in;
      end
   end

   mbx_rx_ram #(
      .DEPTH (RX_DEPTH)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_we),
      .wr_addr (rx_tail),
      .wr_data (rx_wdata),
      .rd_addr (rx_head_in),
      .rd_data (rx_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         txcfg_lo_ff  <= '0;
         txcfg_hi_ff  <= '0;
         txdat_lo_ff  <= '0;
         txdat_hi_ff  <= '0;
         rxw_lo_ff    <= '0;
         rxw_hi_ff    <= '0;
         pend_ff      <= '0;
         mask_ff      <= MASK_INIT;
         ext_word_ff  <= '0;
         irq_ff       <= 1'b0;
         present_ff   <= MASK_INIT;
         rx_head_ff   <= '0;
         rx_count_ff  <= '0;
         for (int i = 0; i < EVEN_DEPTH; i++) begin
            even_bank_ff[i] <= '0;
         end
         for (int i = 0; i < ODD_DEPTH; i++) begin
            odd_bank_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         txcfg_lo_ff  <= txcfg_lo_in;
         txcfg_hi_ff  <= txcfg_hi_in;
         txdat_lo_ff  <= txdat_lo_in;
         txdat_hi_ff  <= txdat_hi_in;
         rxw_lo_ff    <= rxw_lo_in;
         rxw_hi_ff    <= rxw_hi_in;
         pend_ff      <= pend_in;
         mask_ff      <= mask_in;
         ext_word_ff  <= ext_word_in;
         irq_ff       <= irq_in;
         present_ff   <= present_in;
         rx_head_ff   <= rx_head_in;
         rx_count_ff  <= rx_count_in;
         if (even_we) begin
            even_bank_ff[even_idx] <= even_wdata;
         end
         if (odd_we) begin
            odd_bank_ff[odd_idx] <= odd_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   `MBX_ASSERT_IMPLIES(a_rx_count_bound, clock, reset, 1'b1, 32'(rx_count_ff) <= RX_DEPTH)
   `MBX_ASSERT_IMPLIES(a_stall_blocks_req, clock, reset, s1_valid_ff && rsp_valid_ff && !rsp_chan.ready, !req_ready)
   `MBX_ASSERT_NEXT(a_irq_falls_on_clear, clock, reset, irq_ff && !irq_in, pend_ff == '0)
   `MBX_ASSERT_IMPLIES(a_send_is_write, clock, reset, rsp_valid_ff && rsp_ff.send_valid, rsp_ff.access_ok && (rsp_ff.read_data == '0))

endmodule

[hdl/mbx_rx_ram.sv]
// receive queue storage with registered write-first read port
module mbx_rx_ram
   import mbx_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [0:DEPTH-1];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[verif/tb.sv]
// self-checking testbench for the mailbox register block
module tb
   import mbx_pkg::*;
();

   localparam int unsigned NUM_WORDS = 64;
   localparam int unsigned RX_SLOTS = 16;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT = 200000;

   logic clock;
   logic reset;

   mbx_chan_if #(.payload_type(req_payload_type)) req_chan ();
   mbx_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();
   mbx_chan_if #(.payload_type(logic [WORD_W-1:0])) csr_chan ();

   mailbox_register_block i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // mirror of the block state
   logic [WORD_W-1:0] regs [NUM_WORDS];
   logic [DATA_W-1:0] rx_fifo [RX_SLOTS];
   int unsigned rx_head;
   int unsigned rx_count;
   logic irq;
   logic [WORD_W-1:0] present_mask;

   req_payload_type pending_accesses[$];
   rsp_payload_type due_replies[$];
   int unsigned issued_count;
   int unsigned result_count;
   int unsigned errors;
   int unsigned cycle_count;
   int unsigned gap_pct;
   int unsigned stall_pct;
   logic req_fire;

   always #4 clock = ~clock;

   function automatic void refresh_irq();
      if ((regs[WORD_PEND] & ~regs[WORD_MASK] & IRQ_ALL) != 0) irq = 1'b1;
   endfunction

   function automatic rsp_payload_type model_register_access(req_payload_type a);
      rsp_payload_type r;
      int unsigned w;
      int unsigned n;
      logic [DATA_W-1:0] v;
      logic [DATA_W-1:0] tx_cfg;
      logic [7:0] dst;
      logic [4:0] fn;
      logic [WORD_W-1:0] p;
      r = '0;
      w = a.word_addr;
      n = a.wide_access ? 2 : 1;
      r.access_ok = 1'b1;
      if (w + n > NUM_WORDS) begin
         r.access_ok = 1'b0;
      end else if (a.req_type == REQ_READ) begin
         if (w == WORD_RX_LO || w == WORD_RX_HI) begin
            if (rx_count == 0) begin
               regs[WORD_PEND] = regs[WORD_PEND] | IRQ_RX_UDR;
               refresh_irq();
            end else begin
               v = rx_fifo[rx_head];
               if (w == WORD_RX_HI) v = v >> 32;
               if ((a.wide_access && w == WORD_RX_LO) || w == WORD_RX_HI) begin
                  rx_head = (rx_head + 1) % RX_SLOTS;
                  rx_count--;
               end
               r.read_data = a.wide_access ? v : {32'h0, v[31:0]};
            end
         end else begin
            r.read_data = a.wide_access ? {regs[w + 1], regs[w]} : {32'h0, regs[w]};
         end
      end else if (w == WORD_STATUS) begin
         r.access_ok = 1'b0;
      end else if (w == WORD_PEND) begin
         p = regs[WORD_PEND];
         if (p != 0) begin
            p = p & ~a.write_data[31:0];
            regs[WORD_PEND] = p;
            if (p == 0) irq = 1'b0;
         end
      end else if (w == WORD_MASK) begin
         regs[WORD_MASK] = a.write_data[31:0];
         refresh_irq();
      end else begin
         regs[w] = a.write_data[31:0];
         if (a.wide_access) regs[w + 1] = a.write_data[63:32];
         if ((w == WORD_TXDAT_LO && a.wide_access) || (w == WORD_TXDAT_HI && !a.wide_access)) begin
            tx_cfg = {regs[WORD_TXCFG_HI], regs[WORD_TXCFG_LO]};
            dst = tx_cfg[15:8];
            r.send_valid = 1'b1;
            r.send_cfg = tx_cfg;
            r.send_data = {regs[WORD_TXDAT_HI], regs[WORD_TXDAT_LO]};
            if (dst[7]) begin
               fn = dst[4:0];
               if (fn >= MGMT_FN_FIRST && fn <= MGMT_FN_LAST) begin
                  r.send_target = 2'(fn - MGMT_FN_FIRST);
               end else begin
                  r.send_status = SEND_UNSUPPORTED;
               end
            end else begin
               r.send_target = TARGET_LOCAL;
               r.send_bank = dst[4:3];
               r.send_index = dst[2:0];
               if (dst >= 32 || !present_mask[dst[4:0]]) r.send_status = SEND_ABSENT;
            end
         end else if ((w == WORD_RX_LO && a.wide_access) || w == WORD_RX_HI) begin
            if (rx_count < RX_SLOTS) begin
               rx_fifo[(rx_head + rx_count) % RX_SLOTS] = {regs[WORD_RX_HI], regs[WORD_RX_LO]};
               rx_count++;
               if (rx_count % 2 == 0) begin
                  regs[WORD_PEND] = regs[WORD_PEND] | IRQ_RX_VALID;
                  refresh_irq();
               end
            end
         end
      end
      r.irq_line = irq;
      return r;
   endfunction

   function automatic void queue_access(logic rw, int unsigned addr, logic wide,
                                        logic [DATA_W-1:0] data);
      req_payload_type a;
      a.req_type = rw;
      a.word_addr = addr[ADDR_W-1:0];
      a.wide_access = wide;
      a.write_data = data;
      pending_accesses.push_back(a);
   endfunction

   function automatic logic [DATA_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // well-formed sends, pushes and pops with random content, plus some noise
   function automatic void add_random_traffic(int unsigned count);
      int unsigned start;
      int unsigned pick;
      int unsigned burst;
      logic [DATA_W-1:0] cfg;
      logic [7:0] dst;
      start = pending_accesses.size();
      while (pending_accesses.size() - start < count) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            case ($urandom_range(3))
               0: dst = {3'b100, 5'(MGMT_FN_FIRST + $urandom_range(2))};
               1: dst = {1'b1, 7'($urandom)};
               2: dst = {3'b000, 5'($urandom)};
               default: dst = 8'($urandom);
            endcase
            cfg = rand64();
            cfg[15:8] = dst;
            if ($urandom_range(1)) begin
               queue_access(REQ_WRITE, WORD_TXCFG_LO, 1'b1, cfg);
            end else begin
               queue_access(REQ_WRITE, WORD_TXCFG_LO, 1'b0, cfg);
               queue_access(REQ_WRITE, WORD_TXCFG_HI, 1'b0, cfg >> 32);
            end
            case ($urandom_range(2))
               0: queue_access(REQ_WRITE, WORD_TXDAT_LO, 1'b1, rand64());
               1: begin
                  queue_access(REQ_WRITE, WORD_TXDAT_LO, 1'b0, rand64());
                  queue_access(REQ_WRITE, WORD_TXDAT_HI, 1'b0, rand64());
               end
               default: queue_access(REQ_WRITE, WORD_TXDAT_HI, 1'b0, rand64());
            endcase
         end else if (pick < 45) begin
            burst = ($urandom_range(5) == 0) ? $urandom_range(18, 8) : $urandom_range(3, 1);
            repeat (burst) begin
               if ($urandom_range(1)) begin
                  queue_access(REQ_WRITE, WORD_RX_LO, 1'b1, rand64());
               end else begin
                  queue_access(REQ_WRITE, WORD_RX_LO, 1'b0, rand64());
                  queue_access(REQ_WRITE, WORD_RX_HI, 1'b0, rand64());
               end
            end
         end else if (pick < 65) begin
            repeat ($urandom_range(4, 1)) begin
               case ($urandom_range(3))
                  0: queue_access(REQ_READ, WORD_RX_LO, 1'b1, rand64());
                  1: queue_access(REQ_READ, WORD_RX_HI, 1'b0, rand64());
                  2: queue_access(REQ_READ, WORD_RX_LO, 1'b0, rand64());
                  default: queue_access(REQ_READ, WORD_RX_HI, 1'b1, rand64());
               endcase
            end
         end else if (pick < 75) begin
            queue_access(REQ_READ, WORD_PEND, 1'b0, rand64());
            queue_access(REQ_WRITE, WORD_PEND, 1'($urandom),
                         $urandom_range(1) ? rand64() : 64'($urandom_range(3)));
         end else if (pick < 83) begin
            case ($urandom_range(3))
               0: queue_access(REQ_WRITE, WORD_MASK, 1'($urandom), 64'h0);
               1: queue_access(REQ_WRITE, WORD_MASK, 1'($urandom), 64'($urandom_range(3)));
               2: queue_access(REQ_WRITE, WORD_MASK, 1'($urandom), {32'h0, MASK_INIT});
               default: queue_access(REQ_WRITE, WORD_MASK, 1'($urandom), rand64());
            endcase
         end else begin
            queue_access(1'($urandom), $urandom_range(NUM_WORDS - 1), 1'($urandom), rand64());
         end
      end
   endfunction

   task automatic write_core_mask(logic [WORD_W-1:0] m);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.payload <= m;
      do @(posedge clock); while (!csr_chan.ready);
      present_mask = m;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(negedge clock); while (pending_accesses.size() != 0 || issued_count != result_count);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
   endtask

   // request driver and response ready, both on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_fire) begin
         if (pending_accesses.size() != 0 && $urandom_range(99) >= gap_pct) begin
            req_chan.payload <= pending_accesses.pop_front();
            req_chan.valid <= 1'b1;
            issued_count++;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
      rsp_chan.ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   // request transfer: predict the response
   always @(posedge clock) begin
      req_fire <= !reset && req_chan.valid && req_chan.ready;
      if (!reset && req_chan.valid && req_chan.ready)
         due_replies.push_back(model_register_access(req_chan.payload));
   end

   // response transfer: compare with the oldest prediction
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         result_count++;
         got = rsp_chan.payload;
         if (due_replies.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none actual %h", $time, got);
         end else begin
            want = due_replies.pop_front();
            compare_field("access_ok", want.access_ok, got.access_ok);
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("irq_line", want.irq_line, got.irq_line);
            compare_field("send_valid", want.send_valid, got.send_valid);
            compare_field("send_cfg", want.send_cfg, got.send_cfg);
            compare_field("send_data", want.send_data, got.send_data);
            compare_field("send_target", want.send_target, got.send_target);
            compare_field("send_bank", want.send_bank, got.send_bank);
            compare_field("send_index", want.send_index, got.send_index);
            compare_field("send_status", want.send_status, got.send_status);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.payload = '0;
      req_fire = 1'b0;
      issued_count = 0;
      result_count = 0;
      errors = 0;
      cycle_count = 0;
      gap_pct = 13;
      stall_pct = 50;
      foreach (regs[i]) regs[i] = '0;
      foreach (rx_fifo[i]) rx_fifo[i] = '0;
      regs[WORD_STATUS] = STATUS_INIT;
      regs[WORD_MASK] = MASK_INIT;
      rx_head = 0;
      rx_count = 0;
      irq = 1'b0;
      present_mask = '1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // only core 29 present
      write_core_mask(32'h2000_0000);

      queue_access(REQ_READ, WORD_MASK, 1'b1, 64'h0);
      queue_access(REQ_WRITE, WORD_STATUS, 1'b0, '1);
      queue_access(REQ_WRITE, NUM_WORDS - 2, 1'b1, '1);
      queue_access(REQ_READ, NUM_WORDS - 2, 1'b1, 64'h0);
      queue_access(REQ_READ, NUM_WORDS - 1, 1'b1, 64'h0);
      queue_access(REQ_WRITE, NUM_WORDS - 1, 1'b1, '1);
      // empty receive read while masked, then unmask
      queue_access(REQ_READ, WORD_RX_LO, 1'b0, 64'h0);
      queue_access(REQ_WRITE, WORD_MASK, 1'b1, 64'hffff_ffff_0000_0000);
      queue_access(REQ_WRITE, WORD_PEND, 1'b1, '1);
      queue_access(REQ_WRITE, WORD_RX_LO, 1'b1, 64'h0123_4567_89ab_cdef);
      queue_access(REQ_WRITE, WORD_RX_LO, 1'b0, 64'hffff_ffff_0000_0000);
      queue_access(REQ_WRITE, WORD_RX_HI, 1'b0, 64'h0000_0000_ffff_ffff);
      queue_access(REQ_READ, WORD_RX_LO, 1'b0, 64'h0);
      queue_access(REQ_READ, WORD_RX_HI, 1'b0, 64'h0);
      queue_access(REQ_READ, WORD_RX_LO, 1'b1, 64'h0);
      queue_access(REQ_READ, WORD_RX_HI, 1'b1, 64'h0);
      queue_access(REQ_WRITE, WORD_PEND, 1'b0, {32'h0, IRQ_ALL});
      // management functions, unsupported function, present and absent cores
      queue_access(REQ_WRITE, WORD_TXCFG_LO, 1'b1, 64'hffff_ffff_0000_9000);
      queue_access(REQ_WRITE, WORD_TXDAT_LO, 1'b1, '1);
      queue_access(REQ_WRITE, WORD_TXCFG_LO, 1'b0, 64'h0000_9100);
      queue_access(REQ_WRITE, WORD_TXDAT_HI, 1'b0, 64'h0);
      queue_access(REQ_WRITE, WORD_TXCFG_LO, 1'b0, 64'h0000_9200);
      queue_access(REQ_WRITE, WORD_TXDAT_HI, 1'b0, 64'h5);
      queue_access(REQ_WRITE, WORD_TXCFG_LO, 1'b0, 64'h0000_ff00);
      queue_access(REQ_WRITE, WORD_TXDAT_LO, 1'b1, 64'h1);
      queue_access(REQ_WRITE, WORD_TXCFG_LO, 1'b0, 64'h0000_1d00);
      queue_access(REQ_WRITE, WORD_TXDAT_HI, 1'b0, 64'h2);
      queue_access(REQ_WRITE, WORD_TXCFG_LO, 1'b0, 64'h0000_4000);
      queue_access(REQ_WRITE, WORD_TXDAT_HI, 1'b0, 64'h3);
      wait_idle();

      write_core_mask($urandom);
      add_random_traffic(165);
      wait_idle();

      gap_pct = 50;
      stall_pct = 13;
      write_core_mask(32'h0);
      add_random_traffic(165);
      wait_idle();

      gap_pct = 0;
      stall_pct = 0;
      write_core_mask(32'hffff_ffff);
      add_random_traffic(165);
      wait_idle();

      if (due_replies.size() != 0) begin
         errors++;
         $display("%0t: responses missing, expected %0d actual 0", $time, due_replies.size());
      end
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+hdl
hdl/mbx_pkg.sv
hdl/mbx_chan_if.sv
hdl/mbx_rx_ram.sv
hdl/mailbox_register_block.sv
verif/tb.sv
